/* rtl/core/fpcs_pkg.sv */
// shared types, constants and coefficient table of the five-point cubic smoother
package fpcs_pkg;

  // sample width and derived arithmetic widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int SUM_W        = SAMPLE_WIDTH + 8;
  localparam int X_W          = SAMPLE_WIDTH + 5;
  localparam int XL_W         = (X_W + 1) / 2;
  localparam int XH_W         = X_W - XL_W;
  localparam int SHIFT        = X_W + 6;
  localparam int RECIP_W      = X_W + 2;
  localparam int PROD_W       = X_W + RECIP_W;

  // reciprocal of 35, rounded up, scaled by 2^SHIFT
  localparam logic [63:0]        RECIP_FULL = ((64'd1 << SHIFT) + 64'd34) / 64'd35;
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);

  // quotient numerators at or above this saturate
  localparam logic [SUM_W:0] X_CLAMP = (SUM_W + 1)'(35) << (SAMPLE_WIDTH - 1);

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // window and queue sizes
  localparam int TAPS        = 5;
  localparam int WIN_DEPTH   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // filter kinds, in emission order within a record
  localparam logic [2:0] KIND_B0  = 3'd0;
  localparam logic [2:0] KIND_B1  = 3'd1;
  localparam logic [2:0] KIND_INT = 3'd2;
  localparam logic [2:0] KIND_E0  = 3'd3;
  localparam logic [2:0] KIND_E1  = 3'd4;

  // weights per kind, oldest tap first
  localparam logic signed [7:0] COEF [5][5] = '{
    '{ 8'sd69,  8'sd4,  -8'sd6,  8'sd4,  -8'sd1},
    '{ 8'sd2,   8'sd27,  8'sd12, -8'sd8,  8'sd2},
    '{-8'sd3,   8'sd12,  8'sd17,  8'sd12, -8'sd3},
    '{ 8'sd2,  -8'sd8,   8'sd12,  8'sd27,  8'sd2},
    '{-8'sd1,   8'sd4,  -8'sd6,   8'sd4,   8'sd69}
  };

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] taps;   // oldest in entry 0
    logic                              pass;   // short record, emit raw samples
    logic [2:0]                        count;  // number of results
    logic [2:0]                        kind;   // first filter kind
    logic                              last;   // record ends with this job
  } job_t;

  function automatic logic signed [7:0] coef(input logic [2:0] kind, input logic [2:0] tap);
    logic signed [7:0] c;
    c = 8'sd0;
    if (kind <= KIND_E1 && tap < 3'd5) begin
      c = COEF[kind][tap];
    end
    return c;
  endfunction

endpackage

/* rtl/core/fpcs_front.sv */
// front end: sample window, record count and job classification
module fpcs_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fpcs_pkg::SAMPLE_WIDTH-1:0]    sample_i,
  input  logic                                 record_end_i,
  input  logic                                 queue_full_i,
  output logic                                 push_o,
  output fpcs_pkg::job_t                       job_o
);

  logic [fpcs_pkg::SAMPLE_WIDTH-1:0] win_q [fpcs_pkg::WIN_DEPTH];
  logic [2:0]                        count_q, count_d;
  logic                              accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i & ~queue_full_i;

  // classify the incoming sample into a job
  always_comb begin
    job_o.taps  = {sample_i, win_q[3], win_q[2], win_q[1], win_q[0]};
    job_o.pass  = (count_q < 3'd4);
    job_o.last  = record_end_i;
    job_o.kind  = (count_q == 3'd4) ? fpcs_pkg::KIND_B0 : fpcs_pkg::KIND_INT;
    if (count_q < 3'd4) begin
      job_o.count = count_q + 3'd1;
    end else begin
      job_o.count = ((count_q == 3'd4) ? 3'd3 : 3'd1) + (record_end_i ? 3'd2 : 3'd0);
    end
  end

  assign push_o = accept & ((count_q >= 3'd4) | record_end_i);

  // saturating sample count within the record
  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (record_end_i) begin
        count_d = 3'd0;
      end else if (count_q < 3'd5) begin
        count_d = count_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // sample window shift
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < fpcs_pkg::WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[fpcs_pkg::WIN_DEPTH-1] <= sample_i;
    end
  end

endmodule

/* rtl/core/fpcs_job_queue.sv */
// small job queue between the front and back ends
module fpcs_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpcs_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fpcs_pkg::job_t job_o
);

  fpcs_pkg::job_t                   mem_q [fpcs_pkg::QUEUE_DEPTH];
  logic [fpcs_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [fpcs_pkg::QPTR_W:0]        fill_q;
  logic                             do_push, do_pop;

  assign full_o  = (fill_q == (fpcs_pkg::QPTR_W + 1)'(fpcs_pkg::QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/core/fpcs_back.sv */
// back end: expands jobs into results, weighted sum, divide by 35 or 70, saturate; raw samples for short records
module fpcs_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  fpcs_pkg::job_t                    job_i,
  output logic                              job_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fpcs_pkg::SAMPLE_WIDTH-1:0] smoothed_o,
  output logic                              run_last_o,
  output logic                              record_last_o
);

  localparam int W  = fpcs_pkg::SAMPLE_WIDTH;
  localparam int SW = fpcs_pkg::SUM_W;

  // flags that ride along every stage
  typedef struct packed {
    logic         pass;
    logic [W-1:0] raw;
    logic         d70;
    logic         run_last;
    logic         rec_last;
  } tag_t;

  logic                 advance, issue, is_final;
  logic [2:0]           step_q, kind_cur, tap_sel;
  tag_t                 tag_d;
  logic signed [SW-1:0] tap_ext [fpcs_pkg::TAPS];
  logic signed [SW-1:0] coef_ext [fpcs_pkg::TAPS];
  logic signed [SW-1:0] prod_d [fpcs_pkg::TAPS];

  logic                 v1_q, v2_q, v3_q, v4_q, v5_q;
  tag_t                 tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [SW-1:0] prod1_q [fpcs_pkg::TAPS];
  logic signed [SW-1:0] sum2_q, sum2_d;
  logic [SW-1:0]        mag;
  logic [SW:0]          x_full;
  logic                 neg3_q, sat3_q, neg4_q, sat4_q;
  logic [fpcs_pkg::X_W-1:0] x3_q;
  logic [fpcs_pkg::XL_W+fpcs_pkg::RECIP_W-1:0] plo4_q, plo4_d;
  logic [fpcs_pkg::XH_W+fpcs_pkg::RECIP_W-1:0] phi4_q, phi4_d;
  logic [fpcs_pkg::PROD_W-1:0] prod_full;
  logic [W-1:0]         quot, result_d;
  logic [W-1:0]         smoothed_q;
  logic                 run_last_q, rec_last_q;

  // whole pipeline moves unless the output register is held
  assign advance  = ~(v5_q & out_stall_i);
  assign issue    = job_valid_i & advance;
  assign is_final = (step_q == job_i.count - 3'd1);
  assign job_pop_o = issue & is_final;
  assign kind_cur = job_i.kind + step_q;
  assign tap_sel  = 3'd5 - job_i.count + step_q;

  // result step within the current job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else if (issue) begin
      step_q <= is_final ? 3'd0 : step_q + 3'd1;
    end
  end

  // stage 1 inputs: tap products and tags
  always_comb begin
    tag_d.pass     = job_i.pass;
    tag_d.raw      = job_i.taps[tap_sel];
    tag_d.d70      = (kind_cur == fpcs_pkg::KIND_B0) || (kind_cur == fpcs_pkg::KIND_E1);
    tag_d.run_last = is_final;
    tag_d.rec_last = is_final & job_i.last;
    for (int i = 0; i < fpcs_pkg::TAPS; i++) begin
      tap_ext[i]  = SW'($signed(job_i.taps[i]));
      coef_ext[i] = SW'(fpcs_pkg::coef(kind_cur, 3'(i)));
      prod_d[i]   = tap_ext[i] * coef_ext[i];
    end
  end

  // stage 2 input: five-tap sum
  assign sum2_d = prod1_q[0] + prod1_q[1] + prod1_q[2] + prod1_q[3] + prod1_q[4];

  // stage 3 input: magnitude, rounding offset, saturation check
  always_comb begin
    mag = sum2_q[SW-1] ? SW'(-sum2_q) : SW'(sum2_q);
    if (tag2_q.d70) begin
      x_full = ({1'b0, mag} + (SW + 1)'(35)) >> 1;
    end else begin
      x_full = {1'b0, mag} + (SW + 1)'(17);
    end
  end

  // stage 4 input: split reciprocal multiply
  assign plo4_d = (fpcs_pkg::XL_W + fpcs_pkg::RECIP_W)'(x3_q[fpcs_pkg::XL_W-1:0])
                * (fpcs_pkg::XL_W + fpcs_pkg::RECIP_W)'(fpcs_pkg::RECIP);
  assign phi4_d = (fpcs_pkg::XH_W + fpcs_pkg::RECIP_W)'(x3_q[fpcs_pkg::X_W-1:fpcs_pkg::XL_W])
                * (fpcs_pkg::XH_W + fpcs_pkg::RECIP_W)'(fpcs_pkg::RECIP);

  // stage 5 input: combine partial products, restore sign, saturate
  always_comb begin
    prod_full = (fpcs_pkg::PROD_W'(phi4_q) << fpcs_pkg::XL_W) + fpcs_pkg::PROD_W'(plo4_q);
    quot      = prod_full[fpcs_pkg::SHIFT +: W];
    if (tag4_q.pass) begin
      result_d = tag4_q.raw;
    end else if (neg4_q) begin
      result_d = sat4_q ? fpcs_pkg::SAMPLE_MIN : W'(-quot);
    end else begin
      result_d = sat4_q ? fpcs_pkg::SAMPLE_MAX : quot;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (advance) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      tag1_q  <= tag_d;
      prod1_q <= prod_d;
      tag2_q  <= tag1_q;
      sum2_q  <= sum2_d;
      tag3_q  <= tag2_q;
      neg3_q  <= sum2_q[SW-1];
      sat3_q  <= (x_full >= fpcs_pkg::X_CLAMP);
      x3_q    <= fpcs_pkg::X_W'(x_full);
      tag4_q  <= tag3_q;
      neg4_q  <= neg3_q;
      sat4_q  <= sat3_q;
      plo4_q  <= plo4_d;
      phi4_q  <= phi4_d;
      smoothed_q <= result_d;
      run_last_q <= tag4_q.run_last;
      rec_last_q <= tag4_q.rec_last;
    end
  end

  assign out_valid_o   = v5_q;
  assign smoothed_o    = smoothed_q;
  assign run_last_o    = run_last_q;
  assign record_last_o = rec_last_q;

endmodule

/* rtl/core/five_point_cubic_smoother_top.sv */
// top level of the five-point cubic smoother
//
// channel  direction  handshake              payload
// input    in         in_valid_i/in_stall_o  sample_i, record_end_i
// output   out        out_valid_o/out_stall_i smoothed_o, run_last_o, record_last_o
//
// each accepted sample yields zero to five results; the back end issues one result a cycle
// unless the output stalls; jobs are written into the job queue, then pass five pipeline
// stages to the output register; a four-entry job queue absorbs the result bursts at
// record starts and ends; input stalls only while that queue is full, output stall holds
// the whole back pipeline; reset clears the record count, queue pointers and pipeline
// valid bits; window is only read after it has been written within the current record
module five_point_cubic_smoother_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpcs_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                              record_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fpcs_pkg::SAMPLE_WIDTH-1:0] smoothed_o,
  output logic                              run_last_o,
  output logic                              record_last_o
);

  logic           push, queue_full, job_valid, job_pop;
  fpcs_pkg::job_t job_in, job_head;

  // sample window and classification
  fpcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .record_end_i (record_end_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // decoupling queue
  fpcs_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (queue_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  // result expansion and arithmetic
  fpcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .smoothed_o    (smoothed_o),
    .run_last_o    (run_last_o),
    .record_last_o (record_last_o)
  );

endmodule
